@@ rtl/core/ptpf_pkg.sv @@
// Shared widths, status codes, side-band struct and elaboration-time constant functions.
package ptpf_pkg;

  // Field widths of the ports
  localparam int COORD_W  = 24;
  localparam int DEPTH_W  = 32;
  localparam int RADIUS_W = 24;
  localparam int ANGLE_W  = 23;
  localparam int STATUS_W = 2;

  // Default build parameters
  localparam int ITERATIONS_DEF = 24;
  localparam int FRAC_BITS_DEF  = 20;

  // Datapath: extra fraction bits on x/y, and headroom for the CORDIC gain
  localparam int GUARD     = 6;
  localparam int XY_W      = COORD_W + GUARD + 3;
  localparam int GAIN_W    = 31;
  localparam int PROD_W    = XY_W - 1 + GAIN_W;
  localparam int RAD_SHIFT = GAIN_W + GUARD;

  // Depth below this many LSB (about 1e-6 m) counts as zero
  localparam int ZERO_DEPTH_LSB = 17;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK         = 2'd0,
    STATUS_BEHIND     = 2'd1,
    STATUS_ZERO_DEPTH = 2'd2
  } status_t;

  // Values that ride along the chain untouched by the rotations
  typedef struct packed {
    logic                bypass;  // y was zero: radius and angle come straight from x
    logic                x_neg;
    status_t             status;
    logic [COORD_W-1:0]  abs_x;
    logic [DEPTH_W-1:0]  depth;
  } side_t;

  // Unsigned quotient by shift and subtract, one bit per step from the top
  function automatic logic [63:0] udiv64(logic [63:0] num, logic [63:0] den);
    logic [63:0] r;
    logic [63:0] q;
    r = '0;
    q = '0;
    for (int i = 63; i >= 0; i--) begin
      r = {r[62:0], num[i]};
      if (r >= den) begin
        r    = r - den;
        q[i] = 1'b1;
      end
    end
    return q;
  endfunction

  // atan(2^-sh) in Q60 by its alternating series, sh >= 1
  function automatic logic [63:0] atan_pow2_q60(int unsigned sh);
    logic [63:0] p;
    logic [63:0] sum;
    logic [63:0] term;
    logic [63:0] dv;
    p   = 64'd1 << (60 - sh);
    sum = '0;
    for (int k = 0; k < 64; k++) begin
      if (p != 64'd0) begin
        dv   = 64'(2 * k + 1);
        term = udiv64(p, dv);
        if (k[0] == 1'b0) sum = sum + term;
        else              sum = sum - term;
        p = p >> (2 * sh);
      end
    end
    return sum;
  endfunction

  // atan(1/3) in Q60 by the same series
  function automatic logic [63:0] atan_third_q60();
    logic [63:0] p;
    logic [63:0] sum;
    logic [63:0] term;
    logic [63:0] dv;
    p   = udiv64(64'd1 << 60, 64'd3);
    sum = '0;
    for (int k = 0; k < 64; k++) begin
      if (p != 64'd0) begin
        dv   = 64'(2 * k + 1);
        term = udiv64(p, dv);
        if (k[0] == 1'b0) sum = sum + term;
        else              sum = sum - term;
        p = udiv64(p, 64'd9);
      end
    end
    return sum;
  endfunction

  // atan(2^-i) in Q60; the first entry is atan(1/2) + atan(1/3) = pi/4
  function automatic logic [63:0] atan_q60(int unsigned i);
    if (i == 0) return atan_pow2_q60(1) + atan_third_q60();
    return atan_pow2_q60(i);
  endfunction

  function automatic logic [63:0] pi_q60();
    return atan_q60(0) << 2;
  endfunction

  // Round a Q60 value to f fraction bits, half up
  function automatic logic [63:0] round_q60(logic [63:0] v, int unsigned f);
    int unsigned s;
    s = 60 - f;
    return (v + (64'd1 << (s - 1))) >> s;
  endfunction

  function automatic logic [63:0] isqrt64(logic [63:0] v_in);
    logic [63:0] v;
    logic [63:0] res;
    logic [63:0] bits;
    v    = v_in;
    res  = '0;
    bits = 64'd1 << 62;
    for (int s = 0; s < 32; s++) begin
      if (bits > v) bits = bits >> 2;
    end
    for (int s = 0; s < 32; s++) begin
      if (bits != 64'd0) begin
        if (v >= res + bits) begin
          v   = v - (res + bits);
          res = (res >> 1) + bits;
        end else begin
          res = res >> 1;
        end
        bits = bits >> 2;
      end
    end
    return res;
  endfunction

  // 1/K for the given number of micro-rotations, Q0.31 truncated
  function automatic logic [63:0] inv_gain_q31(int unsigned iters);
    logic [63:0] d;
    logic [63:0] r;
    logic [63:0] q;
    d = 64'd1 << 60;
    for (int i = 0; i < 32; i++) begin
      if (i < iters) d = d + (d >> (2 * i));
    end
    r = 64'd1 << 60;
    q = '0;
    for (int i = 0; i < 62; i++) begin
      r = r << 1;
      q = q << 1;
      if (r >= d) begin
        r = r - d;
        q = q | 64'd1;
      end
    end
    return isqrt64(q);
  endfunction

endpackage

@@ rtl/core/ptpf_prerot.sv @@
// Entry stage: scale x/y, fold the left half plane by pi, flag y == 0, classify depth.
module ptpf_prerot #(
  parameter  int FRAC_BITS = ptpf_pkg::FRAC_BITS_DEF,
  localparam int Z_W       = FRAC_BITS + ptpf_pkg::GUARD + 4
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   up_valid,
  output logic                                   up_ready,
  input  logic signed [ptpf_pkg::COORD_W-1:0]    x_coord,
  input  logic signed [ptpf_pkg::COORD_W-1:0]    y_coord,
  input  logic signed [ptpf_pkg::DEPTH_W-1:0]    depth,
  output logic                                   dn_valid,
  input  logic                                   dn_ready,
  output logic signed [ptpf_pkg::XY_W-1:0]       dn_x,
  output logic signed [ptpf_pkg::XY_W-1:0]       dn_y,
  output logic signed [Z_W-1:0]                  dn_z,
  output ptpf_pkg::side_t                        dn_side
);

  localparam logic signed [Z_W-1:0] PI_Z =
    Z_W'(ptpf_pkg::round_q60(ptpf_pkg::pi_q60(), FRAC_BITS + ptpf_pkg::GUARD));

  logic signed [ptpf_pkg::XY_W-1:0]    x_scaled;
  logic signed [ptpf_pkg::XY_W-1:0]    y_scaled;
  logic signed [ptpf_pkg::XY_W-1:0]    x_next;
  logic signed [ptpf_pkg::XY_W-1:0]    y_next;
  logic signed [Z_W-1:0]               z_next;
  logic signed [ptpf_pkg::COORD_W:0]   x_ext;
  ptpf_pkg::side_t                     side_next;

  // Move to the working format and turn the left half plane by pi
  always_comb begin
    x_scaled = ptpf_pkg::XY_W'(x_coord) <<< ptpf_pkg::GUARD;
    y_scaled = ptpf_pkg::XY_W'(y_coord) <<< ptpf_pkg::GUARD;
    x_ext    = (ptpf_pkg::COORD_W + 1)'(x_coord);
    if (x_coord[ptpf_pkg::COORD_W-1]) begin
      x_next = -x_scaled;
      y_next = -y_scaled;
      z_next = y_coord[ptpf_pkg::COORD_W-1] ? -PI_Z : PI_Z;
    end else begin
      x_next = x_scaled;
      y_next = y_scaled;
      z_next = '0;
    end
  end

  // Gather the side band: bypass flag, |x| and the depth check
  always_comb begin
    side_next.bypass = (y_coord == '0);
    side_next.x_neg  = x_coord[ptpf_pkg::COORD_W-1];
    side_next.abs_x  = x_ext[ptpf_pkg::COORD_W] ? ptpf_pkg::COORD_W'(-x_ext)
                                                : ptpf_pkg::COORD_W'(x_ext);
    side_next.depth  = depth;
    if (depth[ptpf_pkg::DEPTH_W-1]) begin
      side_next.status = ptpf_pkg::STATUS_BEHIND;
    end else if (depth < ptpf_pkg::DEPTH_W'(ptpf_pkg::ZERO_DEPTH_LSB)) begin
      side_next.status = ptpf_pkg::STATUS_ZERO_DEPTH;
    end else begin
      side_next.status = ptpf_pkg::STATUS_OK;
    end
  end

  // Take a transfer whenever this stage is empty or is being emptied
  assign up_ready = !dn_valid || dn_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      dn_valid <= 1'b0;
    end else if (up_ready) begin
      dn_valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      dn_x    <= x_next;
      dn_y    <= y_next;
      dn_z    <= z_next;
      dn_side <= side_next;
    end
  end

endmodule

@@ rtl/core/ptpf_cell.sv @@
// One CORDIC vectoring micro-rotation with its own pipeline register and handshake.
module ptpf_cell #(
  parameter  int FRAC_BITS = ptpf_pkg::FRAC_BITS_DEF,
  parameter  int STAGE     = 0,
  localparam int Z_W       = FRAC_BITS + ptpf_pkg::GUARD + 4
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              up_valid,
  output logic                              up_ready,
  input  logic signed [ptpf_pkg::XY_W-1:0]  up_x,
  input  logic signed [ptpf_pkg::XY_W-1:0]  up_y,
  input  logic signed [Z_W-1:0]             up_z,
  input  ptpf_pkg::side_t                   up_side,
  output logic                              dn_valid,
  input  logic                              dn_ready,
  output logic signed [ptpf_pkg::XY_W-1:0]  dn_x,
  output logic signed [ptpf_pkg::XY_W-1:0]  dn_y,
  output logic signed [Z_W-1:0]             dn_z,
  output ptpf_pkg::side_t                   dn_side
);

  // Angle step of this cell, atan(2^-STAGE)
  localparam logic signed [Z_W-1:0] ATAN_STEP =
    Z_W'(ptpf_pkg::round_q60(ptpf_pkg::atan_q60(STAGE), FRAC_BITS + ptpf_pkg::GUARD));

  logic signed [ptpf_pkg::XY_W-1:0] x_shift;
  logic signed [ptpf_pkg::XY_W-1:0] y_shift;
  logic signed [ptpf_pkg::XY_W-1:0] x_next;
  logic signed [ptpf_pkg::XY_W-1:0] y_next;
  logic signed [Z_W-1:0]            z_next;

  // Rotate towards the x axis in the direction that y's sign calls for
  always_comb begin
    x_shift = up_x >>> STAGE;
    y_shift = up_y >>> STAGE;
    if (!up_y[ptpf_pkg::XY_W-1]) begin
      x_next = up_x + y_shift;
      y_next = up_y - x_shift;
      z_next = up_z + ATAN_STEP;
    end else begin
      x_next = up_x - y_shift;
      y_next = up_y + x_shift;
      z_next = up_z - ATAN_STEP;
    end
  end

  // Advance when empty or when the neighbour takes our item
  assign up_ready = !dn_valid || dn_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      dn_valid <= 1'b0;
    end else if (up_ready) begin
      dn_valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      dn_x    <= x_next;
      dn_y    <= y_next;
      dn_z    <= z_next;
      dn_side <= up_side;
    end
  end

endmodule

@@ rtl/core/ptpf_gain.sv @@
// Gain stage: multiply the final x by 1/K, round and clamp the angle, or take the axis angle on bypass.
module ptpf_gain #(
  parameter  int ITERATIONS = ptpf_pkg::ITERATIONS_DEF,
  parameter  int FRAC_BITS  = ptpf_pkg::FRAC_BITS_DEF,
  localparam int Z_W        = FRAC_BITS + ptpf_pkg::GUARD + 4
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 up_valid,
  output logic                                 up_ready,
  input  logic signed [ptpf_pkg::XY_W-1:0]     up_x,
  input  logic signed [Z_W-1:0]                up_z,
  input  ptpf_pkg::side_t                      up_side,
  output logic                                 dn_valid,
  input  logic                                 dn_ready,
  output logic [ptpf_pkg::PROD_W-1:0]          prod,
  output logic signed [ptpf_pkg::ANGLE_W-1:0]  ang,
  output ptpf_pkg::side_t                      dn_side
);

  localparam int ANG_W = Z_W - ptpf_pkg::GUARD;
  localparam logic [ptpf_pkg::GAIN_W-1:0] INV_GAIN =
    ptpf_pkg::GAIN_W'(ptpf_pkg::inv_gain_q31(ITERATIONS));
  localparam logic signed [ANG_W-1:0] PI_OUT =
    ANG_W'(ptpf_pkg::round_q60(ptpf_pkg::pi_q60(), FRAC_BITS));
  localparam logic signed [Z_W-1:0] Z_HALF = Z_W'(2 ** (ptpf_pkg::GUARD - 1));

  logic [ptpf_pkg::XY_W-2:0]           x_pos;
  logic [ptpf_pkg::PROD_W-1:0]         prod_next;
  logic signed [Z_W-1:0]               z_sum;
  logic signed [ANG_W-1:0]             ang_round;
  logic signed [ANG_W-1:0]             ang_sel;
  logic signed [ptpf_pkg::ANGLE_W-1:0] ang_next;

  // Drop a negative x to zero, then scale by the inverse CORDIC gain
  assign x_pos     = up_x[ptpf_pkg::XY_W-1] ? '0 : up_x[ptpf_pkg::XY_W-2:0];
  assign prod_next = x_pos * INV_GAIN;

  // Round off the guard bits, clamp to +-pi, or take the axis angle on bypass
  always_comb begin
    z_sum     = up_z + Z_HALF;
    ang_round = signed'(z_sum[Z_W-1:ptpf_pkg::GUARD]);
    if (up_side.bypass) begin
      ang_sel = up_side.x_neg ? PI_OUT : '0;
    end else if (ang_round > PI_OUT) begin
      ang_sel = PI_OUT;
    end else if (ang_round < -PI_OUT) begin
      ang_sel = -PI_OUT;
    end else begin
      ang_sel = ang_round;
    end
    ang_next = ptpf_pkg::ANGLE_W'(ang_sel);
  end

  assign up_ready = !dn_valid || dn_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      dn_valid <= 1'b0;
    end else if (up_ready) begin
      dn_valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      prod    <= prod_next;
      ang     <= ang_next;
      dn_side <= up_side;
    end
  end

endmodule

@@ rtl/core/ptpf_out.sv @@
// Output stage: round and saturate the radius, hold the result until it is taken.
module ptpf_out (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 up_valid,
  output logic                                 up_ready,
  input  logic [ptpf_pkg::PROD_W-1:0]          prod,
  input  logic signed [ptpf_pkg::ANGLE_W-1:0]  ang,
  input  ptpf_pkg::side_t                      up_side,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic [ptpf_pkg::RADIUS_W-1:0]        radius,
  output logic signed [ptpf_pkg::ANGLE_W-1:0]  angle,
  output logic signed [ptpf_pkg::DEPTH_W-1:0]  depth_out,
  output logic [ptpf_pkg::STATUS_W-1:0]        status
);

  localparam int RWIDE_W = ptpf_pkg::PROD_W - ptpf_pkg::RAD_SHIFT;
  localparam logic [ptpf_pkg::PROD_W-1:0] RAD_HALF =
    ptpf_pkg::PROD_W'(1) << (ptpf_pkg::RAD_SHIFT - 1);

  logic [ptpf_pkg::PROD_W-1:0]   prod_rnd;
  logic [RWIDE_W-1:0]            rad_wide;
  logic [ptpf_pkg::RADIUS_W-1:0] radius_next;

  // Round to nearest, saturate, or pass |x| straight through on bypass
  always_comb begin
    prod_rnd = prod + RAD_HALF;
    rad_wide = prod_rnd[ptpf_pkg::PROD_W-1:ptpf_pkg::RAD_SHIFT];
    if (up_side.bypass) begin
      radius_next = up_side.abs_x;
    end else if (rad_wide[RWIDE_W-1:ptpf_pkg::RADIUS_W] != '0) begin
      radius_next = '1;
    end else begin
      radius_next = rad_wide[ptpf_pkg::RADIUS_W-1:0];
    end
  end

  assign up_ready = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (up_ready) begin
      out_valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      radius    <= radius_next;
      angle     <= ang;
      depth_out <= up_side.depth;
      status    <= up_side.status;
    end
  end

endmodule

@@ rtl/core/point_to_polar_feature_top.sv @@
// Top level of the Cartesian-to-polar point converter: entry stage, CORDIC cell row, gain, output.
//
// Converts an image-plane point (x, y) in Q4.20 to radius and angle by CORDIC vectoring and
// passes the depth through with a status code (behind camera, zero depth, ok). Throughput is
// one point per clock while out_stall is low. The pipeline has one entry stage, one register
// per micro-rotation cell, one stage for the 1/K multiply and one output register. Each stage
// holds its item and takes a new one whenever it is empty or its neighbour takes its item,
// so the pipeline keeps accepting points while a result waits at the output until every stage
// holds a point. Angle and radius of a point with y equal to zero are taken directly from x.
// Status is reported alongside valid radius and angle values; it never suppresses them.
module point_to_polar_feature_top #(
  parameter int ITERATIONS = ptpf_pkg::ITERATIONS_DEF,
  parameter int FRAC_BITS  = ptpf_pkg::FRAC_BITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic signed [ptpf_pkg::COORD_W-1:0]  x_coord,
  input  logic signed [ptpf_pkg::COORD_W-1:0]  y_coord,
  input  logic signed [ptpf_pkg::DEPTH_W-1:0]  depth,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic [ptpf_pkg::RADIUS_W-1:0]        radius,
  output logic signed [ptpf_pkg::ANGLE_W-1:0]  angle,
  output logic signed [ptpf_pkg::DEPTH_W-1:0]  depth_out,
  output logic [ptpf_pkg::STATUS_W-1:0]        status
);

  localparam int Z_W = FRAC_BITS + ptpf_pkg::GUARD + 4;

  logic                               in_ready;
  logic                               valid_chain [ITERATIONS+1];
  logic                               ready_chain [ITERATIONS+1];
  logic signed [ptpf_pkg::XY_W-1:0]   x_chain     [ITERATIONS+1];
  logic signed [ptpf_pkg::XY_W-1:0]   y_chain     [ITERATIONS+1];
  logic signed [Z_W-1:0]              z_chain     [ITERATIONS+1];
  ptpf_pkg::side_t                    side_chain  [ITERATIONS+1];

  logic                               gain_valid;
  logic                               gain_ready;
  logic [ptpf_pkg::PROD_W-1:0]        gain_prod;
  logic signed [ptpf_pkg::ANGLE_W-1:0] gain_ang;
  ptpf_pkg::side_t                    gain_side;

  assign in_stall = !in_ready;

  // Scale, fold the left half plane, classify the depth
  ptpf_prerot #(
    .FRAC_BITS (FRAC_BITS)
  ) u_prerot (
    .clk      (clk),
    .rst      (rst),
    .up_valid (in_valid),
    .up_ready (in_ready),
    .x_coord  (x_coord),
    .y_coord  (y_coord),
    .depth    (depth),
    .dn_valid (valid_chain[0]),
    .dn_ready (ready_chain[0]),
    .dn_x     (x_chain[0]),
    .dn_y     (y_chain[0]),
    .dn_z     (z_chain[0]),
    .dn_side  (side_chain[0])
  );

  // Row of micro-rotation cells, one per iteration
  for (genvar g = 0; g < ITERATIONS; g++) begin : g_cell
    ptpf_cell #(
      .FRAC_BITS (FRAC_BITS),
      .STAGE     (g)
    ) u_cell (
      .clk      (clk),
      .rst      (rst),
      .up_valid (valid_chain[g]),
      .up_ready (ready_chain[g]),
      .up_x     (x_chain[g]),
      .up_y     (y_chain[g]),
      .up_z     (z_chain[g]),
      .up_side  (side_chain[g]),
      .dn_valid (valid_chain[g+1]),
      .dn_ready (ready_chain[g+1]),
      .dn_x     (x_chain[g+1]),
      .dn_y     (y_chain[g+1]),
      .dn_z     (z_chain[g+1]),
      .dn_side  (side_chain[g+1])
    );
  end

  // Remove the CORDIC gain and finish the angle
  ptpf_gain #(
    .ITERATIONS (ITERATIONS),
    .FRAC_BITS  (FRAC_BITS)
  ) u_gain (
    .clk      (clk),
    .rst      (rst),
    .up_valid (valid_chain[ITERATIONS]),
    .up_ready (ready_chain[ITERATIONS]),
    .up_x     (x_chain[ITERATIONS]),
    .up_z     (z_chain[ITERATIONS]),
    .up_side  (side_chain[ITERATIONS]),
    .dn_valid (gain_valid),
    .dn_ready (gain_ready),
    .prod     (gain_prod),
    .ang      (gain_ang),
    .dn_side  (gain_side)
  );

  // Radius rounding and the output register
  ptpf_out u_out (
    .clk       (clk),
    .rst       (rst),
    .up_valid  (gain_valid),
    .up_ready  (gain_ready),
    .prod      (gain_prod),
    .ang       (gain_ang),
    .up_side   (gain_side),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .radius    (radius),
    .angle     (angle),
    .depth_out (depth_out),
    .status    (status)
  );

  // The final y (y_chain[ITERATIONS]) is consumed nowhere; u_gain takes only the x, z and side
  // outputs of the last cell.

endmodule

@@ rtl/core/ptpf_checker.sv @@
// Port-level checks on the converter top level, attached by bind.
module ptpf_checker (
  input logic                                 clk,
  input logic                                 rst,
  input logic                                 in_valid,
  input logic                                 in_stall,
  input logic signed [ptpf_pkg::COORD_W-1:0]  x_coord,
  input logic signed [ptpf_pkg::COORD_W-1:0]  y_coord,
  input logic signed [ptpf_pkg::DEPTH_W-1:0]  depth,
  input logic                                 out_valid,
  input logic                                 out_stall,
  input logic [ptpf_pkg::RADIUS_W-1:0]        radius,
  input logic signed [ptpf_pkg::ANGLE_W-1:0]  angle,
  input logic signed [ptpf_pkg::DEPTH_W-1:0]  depth_out,
  input logic [ptpf_pkg::STATUS_W-1:0]        status
);

  logic depth_neg;
  logic depth_small;

  assign depth_neg   = depth_out[ptpf_pkg::DEPTH_W-1];
  assign depth_small = depth_out < ptpf_pkg::DEPTH_W'(ptpf_pkg::ZERO_DEPTH_LSB);

  // An empty output register means every stage can advance, so input is never held
  a_no_stall_when_drained: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> !in_stall)
    else $error("input stalled while the output register is empty");

  // Status must agree with the depth it travels with
  a_status_matches_depth: assert property (@(posedge clk) disable iff (rst)
    out_valid |->
      (depth_neg && status == ptpf_pkg::STATUS_W'(ptpf_pkg::STATUS_BEHIND)) ||
      (!depth_neg && depth_small &&
       status == ptpf_pkg::STATUS_W'(ptpf_pkg::STATUS_ZERO_DEPTH)) ||
      (!depth_neg && !depth_small && status == ptpf_pkg::STATUS_W'(ptpf_pkg::STATUS_OK)))
    else $error("status does not match depth_out");

  // A held result keeps its value
  a_result_holds: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(radius) && $stable(angle) &&
      $stable(depth_out) && $stable(status))
    else $error("stalled result changed");

  // Nothing comes out on the cycle after reset is released
  a_empty_after_reset: assert property (@(posedge clk)
    $fell(rst) |-> !out_valid)
    else $error("result present straight after reset");

endmodule

bind point_to_polar_feature_top ptpf_checker u_checker (.*);
